### src/tssr_pkg.sv
package tssr_pkg;

  // Frame and activity defaults.
  localparam int unsigned FRAME_BITS_DEF  = 10;
  localparam int unsigned PRESS_WRAPS_DEF = 12;

  // Divider register width and reset value.
  localparam int unsigned DIV_W          = 8;
  localparam logic [DIV_W-1:0] DIV_RESET = 8'd103;

  // Shift word width and load patterns.
  localparam int unsigned WORD_W              = 16;
  localparam logic [WORD_W-1:0] WORD_IDLE     = 16'hFFFF;
  localparam logic [WORD_W-1:0] WORD_START    = 16'hFFFE;

  // Counter widths for bits left and activity.
  localparam int unsigned CNT_W = 4;

  // One result item.
  typedef struct packed {
    logic              frame_done;
    logic [WORD_W-1:0] frame_word;
    logic [WORD_W-1:0] prev_word;
    logic              press_done;
    logic              busy_res;
  } result_t;

endpackage

### src/timer_sampled_serial_receiver.sv
// Timer-sampled serial receiver. Each input transfer is one timer tick with the
// receive line level; each produces exactly one result transfer carrying the
// frame status, the current shift word and the previous frame word. A falling
// edge while idle starts a frame of FRAME_BITS samples taken half a bit period
// after the edge and once per bit after that, with the bit period set by the
// divider register plus one, in ticks. The edge starts an activity count at one
// that grows on every phase wrap; press_done pulses on the wrap at which it
// reaches PRESS_WRAPS, which is PRESS_WRAPS - 1 wraps after the edge.
// Throughput is one tick per clock cycle unless the input stalls: all state
// is updated in the cycle a tick is taken, and the result goes to an output
// register backed by one skid register, so the input only stalls when both are
// full. The divider is written through its own valid/ready port, always ready.
module timer_sampled_serial_receiver
  import tssr_pkg::*;
#(
  parameter int unsigned FRAME_BITS  = FRAME_BITS_DEF,
  parameter int unsigned PRESS_WRAPS = PRESS_WRAPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIV_W-1:0]  cfg_data,
  // Tick input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              rx_level,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              frame_done,
  output logic [WORD_W-1:0] frame_word,
  output logic [WORD_W-1:0] prev_word,
  output logic              press_done,
  output logic              busy_res
);

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);
  localparam logic [CNT_W-1:0] PRESS_CNT = CNT_W'(PRESS_WRAPS);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  // Receiver state
  logic [DIV_W-1:0]  divider;
  logic [DIV_W-1:0]  phase;
  logic [DIV_W-1:0]  sample_phase;
  logic [WORD_W-1:0] shift_word;
  logic [WORD_W-1:0] prev_frame;
  logic [CNT_W-1:0]  bits_left;
  logic              receiving;
  logic              last_level;
  logic [CNT_W-1:0]  activity;

  logic [DIV_W-1:0]  phase_next;
  logic [DIV_W-1:0]  sample_phase_next;
  logic [WORD_W-1:0] shift_word_next;
  logic [WORD_W-1:0] prev_frame_next;
  logic [CNT_W-1:0]  bits_left_next;
  logic              receiving_next;
  logic [CNT_W-1:0]  activity_next;

  // Output register and skid register
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  result_t new_res;

  logic in_xfer;
  logic out_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // Divider register.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= DIV_RESET;
    end else if (cfg_valid && cfg_ready) begin
      divider <= cfg_data;
    end
  end

  // Per-tick update: sample, wrap, edge detection, phase advance.
  always_comb begin
    logic              sample_hit;
    logic              last_sample;
    logic              wrap;
    logic              start_edge;
    logic [CNT_W-1:0]  bits_dec;
    logic [CNT_W-1:0]  act_inc;
    logic [WORD_W-1:0] or_word;
    logic [DIV_W-1:0]  half;
    logic              press;

    sample_hit  = receiving && (phase == sample_phase);
    bits_dec    = bits_left - CNT_ONE;
    last_sample = sample_hit && (bits_dec == '0);
    wrap        = (phase >= divider);
    start_edge  = !receiving && last_level && !rx_level;
    half        = divider >> 1;
    or_word     = shift_word | WORD_W'(rx_level);
    act_inc     = activity + CNT_ONE;

    shift_word_next   = shift_word;
    bits_left_next    = bits_left;
    receiving_next    = receiving;
    prev_frame_next   = prev_frame;
    sample_phase_next = sample_phase;
    activity_next     = activity;
    press             = 1'b0;

    // Sample point.
    if (sample_hit) begin
      bits_left_next = bits_dec;
      if (last_sample) begin
        shift_word_next = or_word;
        receiving_next  = 1'b0;
      end else begin
        shift_word_next = {or_word[WORD_W-2:0], 1'b0};
      end
    end

    // Activity counts phase wraps once started.
    if (wrap && (activity != '0)) begin
      if (act_inc >= PRESS_CNT) begin
        press         = 1'b1;
        activity_next = '0;
      end else begin
        activity_next = act_inc;
      end
    end

    // Falling edge while idle starts a frame.
    if (start_edge) begin
      prev_frame_next = shift_word_next;
      bits_left_next  = FRAME_CNT;
      shift_word_next = WORD_START;
      if (phase < half) begin
        sample_phase_next = phase + half;
      end else begin
        sample_phase_next = phase - half;
      end
      receiving_next = 1'b1;
      activity_next  = CNT_ONE;
    end

    phase_next = wrap ? '0 : phase + DIV_W'(1);

    new_res.frame_done = last_sample;
    new_res.frame_word = shift_word_next;
    new_res.prev_word  = prev_frame_next;
    new_res.press_done = press;
    new_res.busy_res   = receiving_next;
  end

  // State registers advance on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      sample_phase <= '0;
      shift_word   <= WORD_IDLE;
      prev_frame   <= '0;
      bits_left    <= FRAME_CNT;
      receiving    <= 1'b0;
      last_level   <= 1'b1;
      activity     <= '0;
    end else if (in_xfer) begin
      phase        <= phase_next;
      sample_phase <= sample_phase_next;
      shift_word   <= shift_word_next;
      prev_frame   <= prev_frame_next;
      bits_left    <= bits_left_next;
      receiving    <= receiving_next;
      last_level   <= rx_level;
      activity     <= activity_next;
    end
  end

  // Output control: the skid register takes a result while the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_xfer) begin
      out_valid  <= skid_valid || in_xfer;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (!out_valid || out_xfer) begin
      out_res <= skid_valid ? skid_res : new_res;
    end else if (in_xfer) begin
      skid_res <= new_res;
    end
  end

  assign frame_done = out_res.frame_done;
  assign frame_word = out_res.frame_word;
  assign prev_word  = out_res.prev_word;
  assign press_done = out_res.press_done;
  assign busy_res   = out_res.busy_res;

`ifndef SYNTHESIS
  // The skid register is only occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // A frame in progress always has samples left.
  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    receiving |-> (bits_left != '0))
    else $error("receiving with no bits left");

  // The activity counter is cleared before it reaches the press count.
  a_activity_range: assert property (@(posedge clk) disable iff (rst)
    activity < PRESS_CNT)
    else $error("activity counter reached press count");

  // A tick taken while the output is free shows up at the output next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (!out_valid || out_xfer)) |=> out_valid)
    else $error("result of a tick was not presented");
`endif

endmodule
